@@ rtl/core/wsg_pkg.sv @@
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types, widths and constants of the wheel slip grip estimator.
// ----------------------------------------------------------------------------
package wsg_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int NUM_W  = 56;
    localparam int DEN_W  = 48;
    localparam int STEP_W = 6;

    localparam logic [STEP_W-1:0] STEPS_NARROW = 6'd40;
    localparam logic [STEP_W-1:0] STEPS_WIDE   = 6'd56;

    localparam logic [22:0] GRIP_FULL    = 23'd6553600;
    localparam logic [6:0]  GRIP_MAX_PCT = 7'd100;

    localparam logic [31:0] COAST_RST = 32'd500000;
    localparam logic [15:0] ALPHA_RST = 16'd6554;
    localparam logic [15:0] SCALE_RST = 16'd1000;
    localparam logic [15:0] DMAX_RST  = 16'd2048;

    localparam logic [15:0] WHEEL_K   = 16'd62500;
    localparam logic [14:0] DROP_K    = 15'd25600;

    typedef enum logic [1:0] {
        REG_COAST,
        REG_ALPHA,
        REG_SCALE,
        REG_DMAX
    } t_reg;

    typedef enum logic [1:0] {
        DIV_BODY,
        DIV_WHEEL,
        DIV_DROP
    } t_div;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ACC,
        S_DECIDE,
        S_SQX,
        S_SQY,
        S_RSTART,
        S_ROOT,
        S_BSTART,
        S_BODY,
        S_WMUL,
        S_WSTART,
        S_WDIV,
        S_EXCESS,
        S_DMUL,
        S_DSTART,
        S_DROP,
        S_BMUL,
        S_BAPPLY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic acc;
        logic first;
        logic clear_latch;
        logic tgt_full;
        logic tgt_zero;
        logic sq_x;
        logic sq_y;
        logic root_start;
        logic div_start;
        t_div div_sel;
        logic cap_div;
        logic wmul;
        logic excess;
        logic dmul;
        logic bmul;
        logic bapply;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic dt_zero;
        logic have_prev;
        logic rpm_same;
        logic coast;
        logic window_ok;
        logic root_busy;
        logic div_busy;
        logic big;
    } t_sts;

endpackage

@@ rtl/core/wheel_slip_grip_estimator.sv @@
// ----------------------------------------------------------------------------
// wheel_slip_grip_estimator
// Grip estimate from wheel speed against body acceleration, one word out
// for every word in.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  in      | i_in_valid  / o_in_ready   | wheel_rpm, accel_x, accel_y, delta_time_us
//  out     | o_out_valid / i_out_ready  | grip_percent
//  cfg     | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
//  One word at a time. A zero-time word goes straight to the output; first,
//  same-speed and empty-window words skip the arithmetic, and a coasting word
//  runs only the blend. A speed change runs the 32-step root and up to three
//  40/56/40-step passes through the shared divider (two when the excess saturates).
//  Synchronous active-low reset; no clearing pass. A stalled output holds
//  in its register while the next input word is already taken.
// ----------------------------------------------------------------------------
module wheel_slip_grip_estimator
    import wsg_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [19:0]        i_wheel_rpm,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic [15:0]        i_delta_time_us,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [6:0]         o_grip_percent,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    wsg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    wsg_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_wheel_rpm     (i_wheel_rpm),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_delta_time_us (i_delta_time_us),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_grip_percent  (o_grip_percent)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice");

    a_root_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.root_start |=> w_sts.root_busy)
        else $error("root unit did not start");

    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!w_sts.root_busy && !w_sts.div_busy))
        else $error("unit busy while idle");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> (o_out_valid && (o_grip_percent <= GRIP_MAX_PCT)))
        else $error("result not presented");

endmodule

@@ rtl/core/wsg_isqrt.sv @@
// ----------------------------------------------------------------------------
// wsg_isqrt
// Integer square root, rounded down, one result bit per cycle.
// ----------------------------------------------------------------------------
module wsg_isqrt
    import wsg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_value,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0] r_v, r_res, r_bit;
    logic [4:0]      r_cnt;
    logic            r_busy;
    logic [SQ_W-1:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == 5'd31)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
            r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_v >= w_trial) begin
                r_v   <= r_v - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 5'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

@@ rtl/core/wsg_div.sv @@
// ----------------------------------------------------------------------------
// wsg_div
// Restoring unsigned divider, one quotient bit per cycle, variable length.
// ----------------------------------------------------------------------------
module wsg_div
    import wsg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_busy,
    output logic [NUM_W-1:0]  o_quo
);

    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem, r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic [DEN_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == STEP_W'(1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= i_steps;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= DEN_W'(w_trial - {1'b0, r_den});
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q;

endmodule

@@ rtl/core/wsg_ctrl.sv @@
// ----------------------------------------------------------------------------
// wsg_ctrl
// Sequencer of the grip estimator and owner of the input and output handshakes.
// ----------------------------------------------------------------------------
module wsg_ctrl
    import wsg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid;
    t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        w_cmd         = '0;
        w_cmd.div_sel = DIV_BODY;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_ACC;
                end
            end
            S_ACC: begin
                if (i_sts.dt_zero) begin
                    n_state = S_DONE;
                end else begin
                    w_cmd.acc = 1'b1;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.have_prev) begin
                    w_cmd.first       = 1'b1;
                    w_cmd.clear_latch = 1'b1;
                    n_state           = S_DONE;
                end else if (i_sts.rpm_same) begin
                    if (i_sts.coast) begin
                        w_cmd.tgt_full = 1'b1;
                        n_state        = S_BMUL;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (!i_sts.window_ok) begin
                    w_cmd.clear_latch = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                w_cmd.sq_x = 1'b1;
                n_state    = S_SQY;
            end
            S_SQY: begin
                w_cmd.sq_y = 1'b1;
                n_state    = S_RSTART;
            end
            S_RSTART: begin
                w_cmd.root_start = 1'b1;
                n_state          = S_ROOT;
            end
            S_ROOT: begin
                if (!i_sts.root_busy) begin
                    n_state = S_BSTART;
                end
            end
            S_BSTART: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_BODY;
            end
            S_BODY: begin
                if (!i_sts.div_busy) begin
                    w_cmd.cap_div = 1'b1;
                    n_state       = S_WMUL;
                end
            end
            S_WMUL: begin
                w_cmd.wmul = 1'b1;
                n_state    = S_WSTART;
            end
            S_WSTART: begin
                w_cmd.div_sel   = DIV_WHEEL;
                w_cmd.div_start = 1'b1;
                n_state         = S_WDIV;
            end
            S_WDIV: begin
                w_cmd.div_sel = DIV_WHEEL;
                if (!i_sts.div_busy) begin
                    w_cmd.cap_div = 1'b1;
                    n_state       = S_EXCESS;
                end
            end
            S_EXCESS: begin
                w_cmd.excess      = 1'b1;
                w_cmd.clear_latch = 1'b1;
                n_state           = S_DMUL;
            end
            S_DMUL: begin
                if (i_sts.big) begin
                    w_cmd.tgt_zero = 1'b1;
                    n_state        = S_BMUL;
                end else begin
                    w_cmd.dmul = 1'b1;
                    n_state    = S_DSTART;
                end
            end
            S_DSTART: begin
                w_cmd.div_sel   = DIV_DROP;
                w_cmd.div_start = 1'b1;
                n_state         = S_DROP;
            end
            S_DROP: begin
                w_cmd.div_sel = DIV_DROP;
                if (!i_sts.div_busy) begin
                    w_cmd.cap_div = 1'b1;
                    n_state       = S_BMUL;
                end
            end
            S_BMUL: begin
                w_cmd.bmul = 1'b1;
                n_state    = S_BAPPLY;
            end
            S_BAPPLY: begin
                w_cmd.bapply = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/wsg_dp.sv @@
// ----------------------------------------------------------------------------
// wsg_dp
// Datapath: window sums, configuration, root and divider units, grip blend.
// ----------------------------------------------------------------------------
module wsg_dp
    import wsg_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [19:0]        i_wheel_rpm,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic [15:0]        i_delta_time_us,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic [6:0]         o_grip_percent
);

    logic [31:0] r_coast;
    logic [15:0] r_alpha, r_scale, r_dmax;

    logic [19:0]        r_rpm_in, r_prev_rpm;
    logic signed [15:0] r_ax, r_ay;
    logic [15:0]        r_dt;
    logic               r_have;
    logic signed [31:0] r_sx, r_sy;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [31:0]        r_elapsed;
    logic [22:0]        r_grip, r_target;
    logic [SQ_W-1:0]    r_sqx, r_sqy;
    logic [39:0]        r_body, r_dnum;
    logic [35:0]        r_wnum;
    logic [DEN_W-1:0]   r_wden;
    logic [NUM_W-1:0]   r_wheel, r_excess;
    logic [38:0]        r_prod;
    logic               r_up;
    logic [6:0]         r_grip_out;

    logic signed [32:0] w_sx_sum, w_sy_sum;
    logic [32:0]        w_el_sum;
    logic [31:0]        w_mx, w_my;
    logic [15:0]        w_scale_nz, w_dmax_nz;
    logic [19:0]        w_drpm;
    logic [NUM_W-1:0]   w_num, w_quo;
    logic [DEN_W-1:0]   w_den;
    logic [STEP_W-1:0]  w_steps;
    logic [ROOT_W-1:0]  w_root;
    logic               w_root_busy, w_div_busy;
    logic               w_up;
    logic [22:0]        w_diff;
    logic [23:0]        w_step, w_gsum, w_round;
    logic [7:0]         w_pct;

    assign w_sx_sum   = 33'(r_sx) + 33'(r_ax);
    assign w_sy_sum   = 33'(r_sy) + 33'(r_ay);
    assign w_el_sum   = {1'b0, r_elapsed} + 33'(r_dt);
    assign w_mx       = r_sx[31] ? 32'(-r_sx) : 32'(r_sx);
    assign w_my       = r_sy[31] ? 32'(-r_sy) : 32'(r_sy);
    assign w_scale_nz = (r_scale == '0) ? 16'd1 : r_scale;
    assign w_dmax_nz  = (r_dmax == '0) ? 16'd1 : r_dmax;
    assign w_drpm     = (r_rpm_in > r_prev_rpm) ? (r_rpm_in - r_prev_rpm) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coast <= COAST_RST;
            r_alpha <= ALPHA_RST;
            r_scale <= SCALE_RST;
            r_dmax  <= DMAX_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_COAST: r_coast <= i_cfg_data;
                REG_ALPHA: r_alpha <= i_cfg_data[15:0];
                REG_SCALE: r_scale <= i_cfg_data[15:0];
                REG_DMAX:  r_dmax  <= i_cfg_data[15:0];
                default:   r_coast <= r_coast;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rpm_in <= i_wheel_rpm;
            r_ax     <= i_accel_x;
            r_ay     <= i_accel_y;
            r_dt     <= i_delta_time_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rpm <= '0;
            r_have     <= 1'b0;
            r_sx       <= '0;
            r_sy       <= '0;
            r_cnt      <= '0;
            r_elapsed  <= '0;
        end else if (i_cmd.acc) begin
            if (r_cnt != '1) begin
                if (w_sx_sum[32] != w_sx_sum[31]) begin
                    r_sx <= w_sx_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end else begin
                    r_sx <= w_sx_sum[31:0];
                end
                if (w_sy_sum[32] != w_sy_sum[31]) begin
                    r_sy <= w_sy_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end else begin
                    r_sy <= w_sy_sum[31:0];
                end
                r_cnt <= r_cnt + COUNT_BITS'(1);
            end
            r_elapsed <= w_el_sum[32] ? 32'hffff_ffff : w_el_sum[31:0];
        end else if (i_cmd.clear_latch) begin
            r_prev_rpm <= r_rpm_in;
            r_sx       <= '0;
            r_sy       <= '0;
            r_cnt      <= '0;
            r_elapsed  <= '0;
            if (i_cmd.first) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_x) begin
            r_sqx <= 64'(w_mx) * 64'(w_mx);
        end
        if (i_cmd.sq_y) begin
            r_sqy <= 64'(w_my) * 64'(w_my);
        end
        if (i_cmd.wmul) begin
            r_wnum <= 36'(w_drpm) * 36'(WHEEL_K);
            r_wden <= DEN_W'(r_elapsed) * DEN_W'(w_scale_nz);
        end
        if (i_cmd.cap_div) begin
            case (i_cmd.div_sel)
                DIV_BODY:  r_body  <= w_quo[39:0];
                DIV_WHEEL: r_wheel <= w_quo;
                default:   r_target <= (w_quo >= NUM_W'(GRIP_FULL)) ? '0
                                       : GRIP_FULL - w_quo[22:0];
            endcase
        end else if (i_cmd.tgt_full) begin
            r_target <= GRIP_FULL;
        end else if (i_cmd.tgt_zero) begin
            r_target <= '0;
        end
        if (i_cmd.excess) begin
            r_excess <= (r_wheel > NUM_W'(r_body)) ? (r_wheel - NUM_W'(r_body)) : '0;
        end
        if (i_cmd.dmul) begin
            r_dnum <= 40'(r_excess[23:0]) * 40'(DROP_K) + 40'(w_dmax_nz >> 1);
        end
        if (i_cmd.bmul) begin
            r_prod <= 39'(r_alpha) * 39'(w_diff);
            r_up   <= w_up;
        end
    end

    assign w_up   = r_target >= r_grip;
    assign w_diff = w_up ? (r_target - r_grip) : (r_grip - r_target);
    assign w_step = 24'((40'(r_prod) + 40'd32768) >> 16);
    assign w_gsum = 24'(r_grip) + w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grip <= GRIP_FULL;
        end else if (i_cmd.bapply) begin
            if (r_up) begin
                r_grip <= (w_gsum > 24'(GRIP_FULL)) ? GRIP_FULL : w_gsum[22:0];
            end else begin
                r_grip <= r_grip - w_step[22:0];
            end
        end
    end

    assign w_round = 24'(r_grip) + 24'd32768;
    assign w_pct   = w_round[23:16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_grip_out <= (w_pct > 8'(GRIP_MAX_PCT)) ? GRIP_MAX_PCT : w_pct[6:0];
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_BODY: begin
                w_num   = {w_root, 24'd0};
                w_den   = DEN_W'(r_cnt);
                w_steps = STEPS_NARROW;
            end
            DIV_WHEEL: begin
                w_num   = {r_wnum, 20'd0};
                w_den   = r_wden;
                w_steps = STEPS_WIDE;
            end
            DIV_DROP: begin
                w_num   = {r_dnum, 16'd0};
                w_den   = DEN_W'(w_dmax_nz);
                w_steps = STEPS_NARROW;
            end
            default: begin
                w_num   = '0;
                w_den   = '0;
                w_steps = '0;
            end
        endcase
    end

    wsg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_value (r_sqx + r_sqy),
        .o_busy  (w_root_busy),
        .o_root  (w_root)
    );

    wsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_steps (w_steps),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    assign o_sts.dt_zero   = (r_dt == '0);
    assign o_sts.have_prev = r_have;
    assign o_sts.rpm_same  = (r_rpm_in == r_prev_rpm);
    assign o_sts.coast     = (r_elapsed > r_coast);
    assign o_sts.window_ok = (r_elapsed != '0) && (r_cnt != '0);
    assign o_sts.root_busy = w_root_busy;
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.big       = r_excess >= NUM_W'({w_dmax_nz, 8'd0});

    assign o_grip_percent = r_grip_out;

endmodule
